FILE: design/trsm_pkg.sv
// Shared types, constants and codes of the token-ring station MAC.
package trsm_pkg;

	localparam int QUEUE_DEPTH  = 32;
	localparam int LENGTH_WIDTH = 13;
	localparam int ADDR_W       = 8;
	localparam int BUDGET_W     = 24;
	localparam int COUNT_OUT_W  = 6;
	localparam int PTR_W        = $clog2(QUEUE_DEPTH);
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W      = ADDR_W + LENGTH_WIDTH;
	localparam int BITS_W       = LENGTH_WIDTH + 3;
	localparam int SUM_W        = BUDGET_W + 1;
	localparam int CFG_DATA_W   = BUDGET_W;
	localparam int CFG_IDX_W    = 1;

	localparam logic [LENGTH_WIDTH-1:0] TOKEN_OCTETS = LENGTH_WIDTH'(3);
	localparam logic [BUDGET_W-1:0]     BUDGET_RESET = BUDGET_W'(40000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STATION_ADDRESS = 1'b0,
		REG_HOLDING_BUDGET  = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		OP_HOST  = 2'd0,
		OP_TOKEN = 2'd1,
		OP_RING  = 2'd2,
		OP_START = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_FRAME = 2'd1,
		KIND_TOKEN = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		RES_HOST,
		RES_RING,
		RES_START,
		RES_FRAME,
		RES_TOKEN
	} res_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ONE,
		ST_TOK_RD,
		ST_TOK_CHK
	} state_t;

	typedef struct packed {
		logic     accept;
		logic     load;
		res_sel_t sel;
		logic     last;
	} cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic fits;
		logic out_free;
	} status_t;

endpackage

FILE: design/trsm_if.sv
// Valid/ready channel interfaces for the station MAC input and result streams.
interface trsm_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           operation;
	logic [trsm_pkg::ADDR_W-1:0]          dest_address;
	logic [trsm_pkg::ADDR_W-1:0]          source_address;
	logic [trsm_pkg::LENGTH_WIDTH-1:0]    length_bytes;

	modport source (output valid, operation, dest_address, source_address, length_bytes,
		input ready);
	modport sink (input valid, operation, dest_address, source_address, length_bytes,
		output ready);
endinterface

interface trsm_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           ring_out_kind;
	logic [trsm_pkg::ADDR_W-1:0]          out_dest;
	logic [trsm_pkg::ADDR_W-1:0]          out_source;
	logic [trsm_pkg::LENGTH_WIDTH-1:0]    out_length_bytes;
	logic                                 deliver_up;
	logic                                 dropped;
	logic [trsm_pkg::COUNT_OUT_W-1:0]     queue_count;
	logic                                 last;

	modport source (output valid, ring_out_kind, out_dest, out_source, out_length_bytes,
		deliver_up, dropped, queue_count, last, input ready);
	modport sink (input valid, ring_out_kind, out_dest, out_source, out_length_bytes,
		deliver_up, dropped, queue_count, last, output ready);
endinterface

FILE: design/trsm_ctrl.sv
// Controller state machine of the station MAC: sequences items and token service.
module trsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_operation,
	output logic              in_ready,
	input  trsm_pkg::status_t status,
	output trsm_pkg::cmd_t    cmd
);

	trsm_pkg::state_t state_q, state_d;
	trsm_pkg::op_t    op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trsm_pkg::ST_IDLE;
			op_q    <= trsm_pkg::OP_HOST;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				op_q <= trsm_pkg::op_t'(in_operation);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.load   = 1'b0;
		cmd.sel    = trsm_pkg::RES_HOST;
		cmd.last   = 1'b0;
		unique case (state_q)
			trsm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (trsm_pkg::op_t'(in_operation) == trsm_pkg::OP_TOKEN) begin
						state_d = trsm_pkg::ST_TOK_RD;
					end else begin
						state_d = trsm_pkg::ST_ONE;
					end
				end
			end
			trsm_pkg::ST_ONE: begin
				unique case (op_q)
					trsm_pkg::OP_RING:  cmd.sel = trsm_pkg::RES_RING;
					trsm_pkg::OP_START: cmd.sel = trsm_pkg::RES_START;
					default:            cmd.sel = trsm_pkg::RES_HOST;
				endcase
				cmd.last = 1'b1;
				if (status.out_free) begin
					cmd.load = 1'b1;
					state_d  = trsm_pkg::ST_IDLE;
				end
			end
			trsm_pkg::ST_TOK_RD: begin
				// head entry is being read into the datapath register
				state_d = trsm_pkg::ST_TOK_CHK;
			end
			trsm_pkg::ST_TOK_CHK: begin
				if (!status.fill_zero && status.fits) begin
					cmd.sel = trsm_pkg::RES_FRAME;
					if (status.out_free) begin
						cmd.load = 1'b1;
						state_d  = trsm_pkg::ST_TOK_RD;
					end
				end else begin
					cmd.sel  = trsm_pkg::RES_TOKEN;
					cmd.last = 1'b1;
					if (status.out_free) begin
						cmd.load = 1'b1;
						state_d  = trsm_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = trsm_pkg::ST_IDLE;
		endcase
	end

	ast_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> state_q == trsm_pkg::ST_IDLE)
		else $error("item taken outside idle");
	ast_chk_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == trsm_pkg::ST_TOK_RD |=> state_q == trsm_pkg::ST_TOK_CHK)
		else $error("head read not followed by check");
	ast_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> status.out_free)
		else $error("result loaded without room");

endmodule

FILE: design/trsm_dp.sv
// Datapath of the station MAC: config registers, descriptor queue, budget and result register.
module trsm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [trsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trsm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [trsm_pkg::ADDR_W-1:0]       in_dest,
	input  logic [trsm_pkg::ADDR_W-1:0]       in_source,
	input  logic [trsm_pkg::LENGTH_WIDTH-1:0] in_length,
	input  trsm_pkg::cmd_t                    cmd,
	output trsm_pkg::status_t                 status,
	trsm_out_if.source                        out_ch
);

	logic [trsm_pkg::ADDR_W-1:0]       station_q;
	logic [trsm_pkg::BUDGET_W-1:0]     budget_q;
	logic [trsm_pkg::ADDR_W-1:0]       dest_q;
	logic [trsm_pkg::ADDR_W-1:0]       source_q;
	logic [trsm_pkg::LENGTH_WIDTH-1:0] length_q;

	logic [trsm_pkg::ENTRY_W-1:0]      mem_q [trsm_pkg::QUEUE_DEPTH];
	logic [trsm_pkg::ENTRY_W-1:0]      rd_q;
	logic [trsm_pkg::PTR_W-1:0]        head_q, tail_q;
	logic [trsm_pkg::CNT_W-1:0]        fill_q;
	logic [trsm_pkg::BUDGET_W-1:0]     used_q;

	logic                              out_valid_q;
	logic [1:0]                        kind_q;
	logic [trsm_pkg::ADDR_W-1:0]       odest_q, osrc_q;
	logic [trsm_pkg::LENGTH_WIDTH-1:0] olen_q;
	logic                              up_q, drop_q, last_q;
	logic [trsm_pkg::COUNT_OUT_W-1:0]  count_q;

	logic                              full, push, pop;
	logic [trsm_pkg::ADDR_W-1:0]       rd_dest;
	logic [trsm_pkg::LENGTH_WIDTH-1:0] rd_len;
	logic [trsm_pkg::SUM_W-1:0]        sum;
	trsm_pkg::kind_t                   r_kind;
	logic [trsm_pkg::ADDR_W-1:0]       r_dest, r_src;
	logic [trsm_pkg::LENGTH_WIDTH-1:0] r_len;
	logic                              r_up, r_drop;
	logic [trsm_pkg::CNT_W-1:0]        r_count;

	assign full    = fill_q == trsm_pkg::CNT_W'(trsm_pkg::QUEUE_DEPTH);
	assign rd_dest = rd_q[trsm_pkg::ENTRY_W-1 -: trsm_pkg::ADDR_W];
	assign rd_len  = rd_q[trsm_pkg::LENGTH_WIDTH-1:0];
	assign sum     = trsm_pkg::SUM_W'(used_q) + trsm_pkg::SUM_W'({rd_len, 3'b000});
	assign push    = cmd.load && cmd.sel == trsm_pkg::RES_HOST && !full;
	assign pop     = cmd.load && cmd.sel == trsm_pkg::RES_FRAME;

	assign status.fill_zero = fill_q == '0;
	assign status.fits      = sum <= trsm_pkg::SUM_W'(budget_q);
	assign status.out_free  = !out_valid_q || out_ch.ready;

	always_comb begin
		r_kind  = trsm_pkg::KIND_NONE;
		r_dest  = '0;
		r_src   = '0;
		r_len   = '0;
		r_up    = 1'b0;
		r_drop  = 1'b0;
		r_count = fill_q;
		case (cmd.sel)
			trsm_pkg::RES_HOST: begin
				r_drop = full;
				if (!full) begin
					r_count = fill_q + trsm_pkg::CNT_W'(1);
				end
			end
			trsm_pkg::RES_RING: begin
				r_up = dest_q == station_q;
				// strip our own frame, forward anything else
				if (source_q != station_q) begin
					r_kind = trsm_pkg::KIND_FRAME;
					r_dest = dest_q;
					r_src  = source_q;
					r_len  = length_q;
				end
			end
			trsm_pkg::RES_START: begin
				if (station_q == '0) begin
					r_kind = trsm_pkg::KIND_TOKEN;
					r_len  = trsm_pkg::TOKEN_OCTETS;
				end
			end
			trsm_pkg::RES_FRAME: begin
				r_kind  = trsm_pkg::KIND_FRAME;
				r_dest  = rd_dest;
				r_src   = station_q;
				r_len   = rd_len;
				r_count = fill_q - trsm_pkg::CNT_W'(1);
			end
			trsm_pkg::RES_TOKEN: begin
				r_kind = trsm_pkg::KIND_TOKEN;
				r_len  = trsm_pkg::TOKEN_OCTETS;
			end
			default: r_kind = trsm_pkg::KIND_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= '0;
			budget_q  <= trsm_pkg::BUDGET_RESET;
		end else if (cfg_we) begin
			unique case (trsm_pkg::reg_index_t'(cfg_index))
				trsm_pkg::REG_STATION_ADDRESS: station_q <= cfg_data[trsm_pkg::ADDR_W-1:0];
				trsm_pkg::REG_HOLDING_BUDGET:  budget_q  <= cfg_data;
				default:                       budget_q  <= budget_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dest_q   <= in_dest;
			source_q <= in_source;
			length_q <= in_length;
		end
	end

	// descriptor store: one write port, one registered read at the head
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= {dest_q, length_q};
		end
		rd_q <= mem_q[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			used_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == trsm_pkg::PTR_W'(trsm_pkg::QUEUE_DEPTH - 1)) ?
					'0 : tail_q + trsm_pkg::PTR_W'(1);
				fill_q <= fill_q + trsm_pkg::CNT_W'(1);
			end
			if (pop) begin
				head_q <= (head_q == trsm_pkg::PTR_W'(trsm_pkg::QUEUE_DEPTH - 1)) ?
					'0 : head_q + trsm_pkg::PTR_W'(1);
				fill_q <= fill_q - trsm_pkg::CNT_W'(1);
				used_q <= sum[trsm_pkg::BUDGET_W-1:0];
			end
			if (cmd.accept) begin
				used_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= r_kind;
			odest_q <= r_dest;
			osrc_q  <= r_src;
			olen_q  <= r_len;
			up_q    <= r_up;
			drop_q  <= r_drop;
			count_q <= trsm_pkg::COUNT_OUT_W'(r_count);
			last_q  <= cmd.last;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.ring_out_kind    = kind_q;
	assign out_ch.out_dest         = odest_q;
	assign out_ch.out_source       = osrc_q;
	assign out_ch.out_length_bytes = olen_q;
	assign out_ch.deliver_up       = up_q;
	assign out_ch.dropped          = drop_q;
	assign out_ch.queue_count      = count_q;
	assign out_ch.last             = last_q;

	ast_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= trsm_pkg::CNT_W'(trsm_pkg::QUEUE_DEPTH))
		else $error("queue fill beyond depth");
	ast_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> fill_q != '0)
		else $error("pop from empty queue");
	ast_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || full) |-> head_q == tail_q)
		else $error("head and tail disagree with fill");
	ast_used_in_budget: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> used_q <= budget_q)
		else $error("sent bits exceed holding budget");

endmodule

FILE: design/token_ring_station_mac.sv
// Top level of the token-ring station MAC: controller plus datapath.
//
// Input channel in_ch carries one item per transfer: a host frame, a token
// from the ring, a data frame from the ring, or a start request. Output
// channel out_ch carries result items; every input yields one or more
// results and the final one has last set. The block takes one item at a
// time: in_ch.ready is high only while nothing is in progress.
// Host, ring and start items pass through state ONE: the result register
// loads there once it is free, and in_ch.ready returns after that load.
// A token reads the head descriptor (TOK_RD) and checks it against the
// budget (TOK_CHK) for each frame sent and once more before the release.
// The cfg port writes station_address (index 0) and holding_budget_bits
// (index 1); write only while the block is idle.
// Reset clears queue pointers, fill count and the result valid flag and
// loads the register defaults; queue entries hold junk until written.
// A stalled receiver holds the result register; the controller waits in
// place until that register frees, so nothing is lost or repeated.
module token_ring_station_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	trsm_in_if.sink                           in_ch,
	trsm_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [trsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	trsm_pkg::cmd_t    cmd;
	trsm_pkg::status_t status;
	logic              in_ready;

	// ready comes straight from the controller's idle state
	assign in_ch.ready = in_ready;

	trsm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_operation (in_ch.operation),
		.in_ready     (in_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// queue, budget accumulator and result register
	trsm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_dest   (in_ch.dest_address),
		.in_source (in_ch.source_address),
		.in_length (in_ch.length_bytes),
		.cmd       (cmd),
		.status    (status),
		.out_ch    (out_ch)
	);

endmodule

FILE: tb/sv/tb_token_ring_station_mac.sv
`timescale 1ns / 1ps
// Self-checking testbench of the token-ring station MAC: directed and random traffic.
module tb_token_ring_station_mac;
	import trsm_pkg::*;

	// Cycles without any transfer before the run is declared hung. The slowest
	// legal stretch is a drain plus register writes.
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_LEN     = (1 << LENGTH_WIDTH) - 1;
	localparam int MAX_REPORTS = 10;

	// One item offered on the input channel.
	typedef struct packed {
		op_t                     op;
		logic [ADDR_W-1:0]       dest;
		logic [ADDR_W-1:0]       source;
		logic [LENGTH_WIDTH-1:0] len;
	} station_item_t;

	// One result item as seen on the output channel.
	typedef struct packed {
		kind_t                   kind;
		logic [ADDR_W-1:0]       dest;
		logic [ADDR_W-1:0]       source;
		logic [LENGTH_WIDTH-1:0] len;
		logic                    up;
		logic                    drop;
		logic [COUNT_OUT_W-1:0]  count;
		logic                    last;
	} ring_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	trsm_in_if  in_ch();
	trsm_out_if out_ch();

	token_ring_station_mac i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Items waiting to be driven, and results the block still owes us.
	station_item_t station_items[$];
	ring_result_t  mac_results_due[$];
	int            items_queued;
	int            items_accepted;

	// Shadow of the station: registers and the descriptor FIFO.
	logic [ADDR_W-1:0]       shadow_station = '0;
	logic [BUDGET_W-1:0]     shadow_budget  = BUDGET_RESET;
	logic [ADDR_W-1:0]       fifo_dest[QUEUE_DEPTH];
	logic [LENGTH_WIDTH-1:0] fifo_len[QUEUE_DEPTH];
	int                      fifo_rd   = 0;
	int                      fifo_wr   = 0;
	int                      fifo_fill = 0;

	int   mac_errors  = 0;
	int   idle_cycles = 0;
	logic in_took;
	logic no_idle;

	// Idle-burst bookkeeping for both sides; a quiet count gives stretches
	// with no idling at all.
	int send_gap  = 0;
	int tx_quiet  = 0;
	int rx_stall  = 0;
	int rx_quiet  = 0;

	station_item_t seen_item;
	station_item_t next_item;
	ring_result_t  got_result;
	ring_result_t  want_result;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Build one result; the queue count is the fill after the step so far.
	function automatic ring_result_t make_result(kind_t kind, logic [ADDR_W-1:0] dest,
		logic [ADDR_W-1:0] source, logic [LENGTH_WIDTH-1:0] len, logic up, logic drop);
		ring_result_t r;
		r.kind   = kind;
		r.dest   = dest;
		r.source = source;
		r.len    = len;
		r.up     = up;
		r.drop   = drop;
		r.count  = COUNT_OUT_W'(fifo_fill);
		r.last   = 1'b0;
		return r;
	endfunction

	// Work out every result an accepted item causes and queue them in order.
	task automatic predict_mac_results(input station_item_t it);
		longint unsigned bits_used;
		longint unsigned frame_bits;
		bit              budget_hit;
		logic            drop;
		bits_used  = 0;
		budget_hit = 1'b0;
		case (it.op)
			OP_HOST: begin
				// Queue the descriptor, or drop the frame when the FIFO is full.
				drop = (fifo_fill >= QUEUE_DEPTH);
				if (!drop) begin
					fifo_dest[fifo_wr] = it.dest;
					fifo_len[fifo_wr]  = it.len;
					fifo_wr = (fifo_wr + 1) % QUEUE_DEPTH;
					fifo_fill++;
				end
				mac_results_due.push_back(make_result(KIND_NONE, '0, '0, '0, 1'b0, drop));
			end
			OP_TOKEN: begin
				// Send from the head while the running bit count stays within
				// the budget; stop at the first frame that would exceed it.
				while (fifo_fill > 0 && !budget_hit) begin
					frame_bits = 8 * longint'(fifo_len[fifo_rd]);
					if (bits_used + frame_bits > longint'(shadow_budget)) begin
						budget_hit = 1'b1;
					end else begin
						bits_used += frame_bits;
						fifo_fill--;
						mac_results_due.push_back(make_result(KIND_FRAME, fifo_dest[fifo_rd],
							shadow_station, fifo_len[fifo_rd], 1'b0, 1'b0));
						fifo_rd = (fifo_rd + 1) % QUEUE_DEPTH;
					end
				end
				mac_results_due.push_back(make_result(KIND_TOKEN, '0, '0, TOKEN_OCTETS,
					1'b0, 1'b0));
			end
			OP_RING: begin
				// Strip our own frames, forward the rest; copy up if addressed here.
				if (it.source == shadow_station) begin
					mac_results_due.push_back(make_result(KIND_NONE, '0, '0, '0,
						it.dest == shadow_station, 1'b0));
				end else begin
					mac_results_due.push_back(make_result(KIND_FRAME, it.dest, it.source,
						it.len, it.dest == shadow_station, 1'b0));
				end
			end
			default: begin
				// Only station zero issues the first token.
				if (shadow_station == '0) begin
					mac_results_due.push_back(make_result(KIND_TOKEN, '0, '0, TOKEN_OCTETS,
						1'b0, 1'b0));
				end else begin
					mac_results_due.push_back(make_result(KIND_NONE, '0, '0, '0, 1'b0, 1'b0));
				end
			end
		endcase
		mac_results_due[mac_results_due.size() - 1].last = 1'b1;
	endtask

	function automatic bit same_result(ring_result_t a, ring_result_t b);
		return a.kind === b.kind && a.dest === b.dest && a.source === b.source &&
			a.len === b.len && a.up === b.up && a.drop === b.drop &&
			a.count === b.count && a.last === b.last;
	endfunction

	function automatic string fmt_result(ring_result_t r);
		return $sformatf("kind=%0d dest=%0d src=%0d len=%0d up=%0b drop=%0b count=%0d last=%0b",
			r.kind, r.dest, r.source, r.len, r.up, r.drop, r.count, r.last);
	endfunction

	task automatic flag_mismatch(input string what, input ring_result_t want,
		input ring_result_t got);
		mac_errors++;
		if (mac_errors <= MAX_REPORTS) begin
			$display("%0t %s", $realtime, what);
			$display("  expected %s", fmt_result(want));
			$display("  actual   %s", fmt_result(got));
		end
	endtask

	// Monitor: sample both channels at the rising edge. Predict on every input
	// transfer and check every output transfer against the oldest expectation.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready) begin
				seen_item.op     = op_t'(in_ch.operation);
				seen_item.dest   = in_ch.dest_address;
				seen_item.source = in_ch.source_address;
				seen_item.len    = in_ch.length_bytes;
				predict_mac_results(seen_item);
				items_accepted++;
			end
			if (out_ch.valid && out_ch.ready) begin
				got_result.kind   = kind_t'(out_ch.ring_out_kind);
				got_result.dest   = out_ch.out_dest;
				got_result.source = out_ch.out_source;
				got_result.len    = out_ch.out_length_bytes;
				got_result.up     = out_ch.deliver_up;
				got_result.drop   = out_ch.dropped;
				got_result.count  = out_ch.queue_count;
				got_result.last   = out_ch.last;
				if (mac_results_due.size() == 0) begin
					flag_mismatch("result with nothing expected", make_result(KIND_NONE,
						'0, '0, '0, 1'b0, 1'b0), got_result);
				end else begin
					want_result = mac_results_due.pop_front();
					if (!same_result(want_result, got_result))
						flag_mismatch("result mismatch", want_result, got_result);
				end
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Driver: change inputs at the falling edge. Hold an offered item until its
	// transfer, then advance to the next one, sometimes after an idle burst.
	always @(negedge clk) begin
		if (tx_quiet > 0)
			tx_quiet--;
		else if ($urandom_range(0, 49) == 0)
			tx_quiet = $urandom_range(20, 60);
		if (arst_n && (!in_ch.valid || in_took)) begin
			if (send_gap == 0 && !no_idle && tx_quiet == 0 && station_items.size() != 0 &&
				$urandom_range(0, 5) == 0)
				send_gap = $urandom_range(1, 6);
			if (send_gap > 0) begin
				send_gap--;
				in_ch.valid <= 1'b0;
			end else if (station_items.size() != 0) begin
				next_item = station_items.pop_front();
				in_ch.valid          <= 1'b1;
				in_ch.operation      <= next_item.op;
				in_ch.dest_address   <= next_item.dest;
				in_ch.source_address <= next_item.source;
				in_ch.length_bytes   <= next_item.len;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result side: stall the receiver in random bursts.
	always @(negedge clk) begin
		if (rx_quiet > 0)
			rx_quiet--;
		else if ($urandom_range(0, 49) == 0)
			rx_quiet = $urandom_range(20, 60);
		if (rx_stall == 0 && !no_idle && rx_quiet == 0 && $urandom_range(0, 5) == 0)
			rx_stall = $urandom_range(1, 6);
		if (rx_stall > 0) begin
			rx_stall--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Watchdog: end the run when nothing has moved for too long.
	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("tb_token_ring_station_mac: FAIL");
		$finish;
	end

	// Write one register and keep the shadow copy in step.
	task automatic write_cfg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_STATION_ADDRESS: shadow_station = value[ADDR_W-1:0];
			default:             shadow_budget  = value[BUDGET_W-1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [ADDR_W-1:0] station,
		input logic [BUDGET_W-1:0] budget);
		write_cfg(REG_STATION_ADDRESS, CFG_DATA_W'(station));
		write_cfg(REG_HOLDING_BUDGET, budget);
	endtask

	task automatic push_item(input op_t op, input logic [ADDR_W-1:0] dest,
		input logic [ADDR_W-1:0] source, input logic [LENGTH_WIDTH-1:0] len);
		station_items.push_back('{op: op, dest: dest, source: source, len: len});
		items_queued++;
	endtask

	// Wait until every item is taken and every result is back, then let the
	// block settle before touching the registers.
	task automatic drain_mac();
		while (items_accepted != items_queued || mac_results_due.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Frame lengths: mostly small, some right around the budget edge, some full range.
	function automatic logic [LENGTH_WIDTH-1:0] pick_length();
		int edge_len;
		edge_len = shadow_budget / 8;
		if (edge_len > MAX_LEN)
			edge_len = MAX_LEN;
		case ($urandom_range(0, 3))
			0: return LENGTH_WIDTH'($urandom_range(0, 64));
			1: return LENGTH_WIDTH'($urandom_range(edge_len > 2 ? edge_len - 2 : 0,
				edge_len + 2 > MAX_LEN ? MAX_LEN : edge_len + 2));
			2: return LENGTH_WIDTH'($urandom_range(0, MAX_LEN));
			default: return LENGTH_WIDTH'($urandom_range(0, 1000));
		endcase
	endfunction

	// Random traffic: mostly host bursts closed by a token, the occasional long
	// burst that overruns the FIFO, ring frames aimed at or from this station,
	// starts, bare tokens, and some fully random noise.
	task automatic queue_random_traffic(input int n_items);
		int   added;
		int   burst;
		int   pick;
		logic [ADDR_W-1:0] d;
		logic [ADDR_W-1:0] s;
		added = 0;
		while (added < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				burst = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36)
					: $urandom_range(1, 8);
				repeat (burst) begin
					push_item(OP_HOST, ADDR_W'($urandom), ADDR_W'($urandom), pick_length());
					added++;
				end
				if ($urandom_range(0, 99) < 85) begin
					push_item(OP_TOKEN, ADDR_W'($urandom), ADDR_W'($urandom), pick_length());
					added++;
				end
			end else if (pick < 65) begin
				d = $urandom_range(0, 1) ? shadow_station : ADDR_W'($urandom);
				s = ($urandom_range(0, 2) == 0) ? shadow_station : ADDR_W'($urandom);
				push_item(OP_RING, d, s, pick_length());
				added++;
			end else if (pick < 72) begin
				push_item(OP_START, ADDR_W'($urandom), ADDR_W'($urandom), pick_length());
				added++;
			end else if (pick < 80) begin
				push_item(OP_TOKEN, ADDR_W'($urandom), ADDR_W'($urandom), pick_length());
				added++;
			end else begin
				push_item(op_t'($urandom_range(0, 3)), ADDR_W'($urandom), ADDR_W'($urandom),
					LENGTH_WIDTH'($urandom_range(0, MAX_LEN)));
				added++;
			end
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		no_idle              = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_STATION_ADDRESS;
		cfg_data             = '0;
		in_ch.valid          = 1'b0;
		in_ch.operation      = OP_HOST;
		in_ch.dest_address   = '0;
		in_ch.source_address = '0;
		in_ch.length_bytes   = '0;
		out_ch.ready         = 1'b0;
		items_queued         = 0;
		items_accepted       = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Station zero with the default budget of 40000 bits.
		configure(8'd0, BUDGET_RESET);
		push_item(OP_START, 8'd0, 8'd0, 13'd0);          // station zero issues a token
		push_item(OP_TOKEN, 8'd0, 8'd0, 13'd0);          // empty FIFO: release only
		push_item(OP_HOST, 8'd0, 8'hFF, 13'd0);          // zero-length frame
		push_item(OP_HOST, 8'hA5, 8'd0, 13'd5000);       // lands exactly on the budget
		push_item(OP_HOST, 8'h5A, 8'd0, 13'd5001);       // one octet over
		push_item(OP_HOST, 8'hFF, 8'hFF, 13'h1FFF);      // longest frame
		push_item(OP_TOKEN, 8'hFF, 8'hFF, 13'h1FFF);     // sends two, stops at the third
		push_item(OP_TOKEN, 8'd0, 8'd0, 13'd0);          // head too big: release only
		push_item(OP_RING, 8'd0, 8'd0, 13'h1FFF);        // to and from here: copy and strip
		push_item(OP_RING, 8'd0, 8'hFF, 13'h1FFF);       // to here: copy and forward
		push_item(OP_RING, 8'hFF, 8'd0, 13'd1);          // ours: strip
		push_item(OP_RING, 8'h7F, 8'h80, 13'd0);         // someone else's: forward
		drain_mac();

		// Station 255 with the largest budget: the leftover frames all go.
		configure(8'hFF, {BUDGET_W{1'b1}});
		push_item(OP_START, 8'hFF, 8'hFF, 13'h1FFF);     // not station zero: nothing
		push_item(OP_RING, 8'hFF, 8'hFF, 13'd3);
		push_item(OP_RING, 8'hFF, 8'd0, 13'd100);
		push_item(OP_RING, 8'd0, 8'hFF, 13'd0);
		push_item(OP_HOST, 8'd1, 8'd2, 13'h1FFF);
		push_item(OP_HOST, 8'hFE, 8'd2, 13'd0);
		push_item(OP_TOKEN, 8'd0, 8'd0, 13'd0);
		push_item(OP_TOKEN, 8'd0, 8'd0, 13'd0);
		drain_mac();

		// Random phases across several register settings, each drained before
		// the next so the registers change only while the block is idle.
		configure(ADDR_W'($urandom_range(1, 254)), BUDGET_W'($urandom_range(0, 200000)));
		queue_random_traffic(36);
		drain_mac();

		configure(8'd0, '0);
		queue_random_traffic(36);
		drain_mac();

		configure(8'hFF, {BUDGET_W{1'b1}});
		queue_random_traffic(36);
		drain_mac();

		configure(ADDR_W'($urandom), BUDGET_W'(800));
		queue_random_traffic(36);
		drain_mac();

		// Final phase runs with no idling on either side.
		no_idle = 1'b1;
		configure(ADDR_W'($urandom), BUDGET_W'($urandom_range(0, 100000)));
		queue_random_traffic(36);
		drain_mac();

		if (mac_errors == 0 && mac_results_due.size() == 0) begin
			$display("tb_token_ring_station_mac: PASS");
		end else begin
			$display("tb_token_ring_station_mac: FAIL");
		end
		$finish;
	end

endmodule
